// File: hw/rtl/ncc_pkg.sv
// ncc_pkg: shared types and constants of the nearest-centroid classifier.
// No dependencies; used by the top level, ncc_cell and ncc_checker.
package ncc_pkg;

	// field widths fixed by the interface
	localparam int FEAT_W       = 16;
	localparam int CLS_W        = 4;
	localparam int MAX_FEATURES = 10;

	// fixed-point scaling
	localparam int ROOT_SHIFT = 26;   // S << 26 before the root
	localparam int NORM_SHIFT = 28;   // x << 28 before the divide

	localparam logic [FEAT_W-1:0] ONE_Q15  = 16'd32768;
	localparam logic [FEAT_W-1:0] DIST_SAT = 16'hFFFF;

	// request modes
	localparam logic [1:0] MODE_CLASSIFY    = 2'd0;
	localparam logic [1:0] MODE_LOAD_ROW    = 2'd1;
	localparam logic [1:0] MODE_LOAD_RADIUS = 2'd2;
	localparam logic [1:0] MODE_RESERVED    = 2'd3;   // ignored

	// configuration register indexes
	localparam logic REG_INNER   = 1'b0;
	localparam logic REG_CLASSES = 1'b1;

	localparam logic [4:0] CLASSES_RESET = 5'd8;

	// token passed down the cell chain
	typedef struct packed {
		logic             valid;
		logic [CLS_W-1:0] cls;
	} tok_t;

endpackage

// File: hw/rtl/nearest_centroid_classifier_core.sv
// Nearest-centroid classifier, top level: FSM, chain of feature cells, roots, divider.
// Classify request: sum of squares, 31-step input root, 16-step normalising divide,
// class scan, 17-step distance roots, then a 15-step confidence divide when needed;
// a zero vector ends after the sum of squares. Loads are written when accepted;
// one request at a time. Reset clears tables, configuration and control state.
module nearest_centroid_classifier_core #(
	parameter int FEATURES = 10,
	parameter int CLASSES  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  class_slot,
	input  logic [15:0] feature_0,
	input  logic [15:0] feature_1,
	input  logic [15:0] feature_2,
	input  logic [15:0] feature_3,
	input  logic [15:0] feature_4,
	input  logic [15:0] feature_5,
	input  logic [15:0] feature_6,
	input  logic [15:0] feature_7,
	input  logic [15:0] feature_8,
	input  logic [15:0] feature_9,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        known,
	output logic [3:0]  best_class,
	output logic        second_valid,
	output logic [3:0]  second_class,
	output logic [15:0] confidence,
	output logic [15:0] best_distance,
	output logic [15:0] runner_up_distance,
	output logic        zero_input
);
	import ncc_pkg::*;

	localparam int SUM_W   = 2 * FEAT_W + $clog2(FEATURES);
	localparam int SQ_IN_W = SUM_W + ROOT_SHIFT + (SUM_W % 2);
	localparam int ROOT_W  = SQ_IN_W / 2;
	localparam int DQ_IN_W = SUM_W - 2 + (SUM_W % 2);
	localparam int D_W     = DQ_IN_W / 2;
	localparam int CIDX_W  = $clog2(CLASSES);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SUMSQ, ST_ROOT, ST_NORM, ST_SCAN,
		ST_SQGO, ST_SQD, ST_CALC, ST_CONF, ST_DONE
	} state_t;

	state_t            state_q;
	logic              sent_q;
	logic [4:0]        cnt_q;
	logic [SUM_W-1:0]  best_d2_q, sec_d2_q;
	logic [CLS_W-1:0]  best_q, sec_q;
	logic              best_ok_q, sec_ok_q, zero_q;
	logic [D_W-1:0]    d_q;
	logic [FEAT_W-1:0] sd_q, conf_q;
	logic [FEAT_W-1:0] inner_q;
	logic [4:0]        cu_q;
	logic [FEAT_W-1:0] radius_q [CLASSES];

	logic              out_valid_q, known_q, sec_valid_q, zero_out_q;
	logic [CLS_W-1:0]  best_out_q, sec_out_q;
	logic [FEAT_W-1:0] conf_out_q, bd_out_q, sd_out_q;

	logic [FEAT_W-1:0] feat [MAX_FEATURES];
	tok_t              tok_w [FEATURES+1];
	logic [SUM_W-1:0]  sum_w [FEATURES+1];
	logic [FEATURES-1:0] cell_done;

	logic              accept, slot_ok, use_norm, cell_start;
	logic [4:0]        used;
	logic              rsq_done, bsq_done, ssq_done, sq_go;
	logic [ROOT_W-1:0] r_root;
	logic [D_W-1:0]    b_root, s_root;
	logic [FEAT_W-1:0] outer;
	logic              need_div, cdiv_done;
	logic [FEAT_W-2:0] cdiv_quo;
	tok_t              tok_end;
	logic [SUM_W-1:0]  sum_end;
	logic              load_out;

	assign feat[0] = feature_0;
	assign feat[1] = feature_1;
	assign feat[2] = feature_2;
	assign feat[3] = feature_3;
	assign feat[4] = feature_4;
	assign feat[5] = feature_5;
	assign feat[6] = feature_6;
	assign feat[7] = feature_7;
	assign feat[8] = feature_8;
	assign feat[9] = feature_9;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign slot_ok  = (5'(class_slot) < 5'(CLASSES));

	// classes searched, clamped to 1..CLASSES
	always_comb begin
		if (cu_q == '0) begin
			used = 5'd1;
		end else if (cu_q > 5'(CLASSES)) begin
			used = 5'(CLASSES);
		end else begin
			used = cu_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			cu_q    <= CLASSES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INNER:   inner_q <= cfg_data;
				REG_CLASSES: cu_q    <= cfg_data[4:0];
				default:     ;
			endcase
		end
	end

	// outer radius table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASSES; i++) begin
				radius_q[i] <= '0;
			end
		end else if (accept && mode == MODE_LOAD_RADIUS && slot_ok) begin
			radius_q[class_slot[CIDX_W-1:0]] <= feature_0;
		end
	end

	// chain head: one token for the sum of squares, then one per class
	always_comb begin
		tok_w[0] = '0;
		sum_w[0] = '0;
		if (state_q == ST_SUMSQ) begin
			tok_w[0].valid = !sent_q;
		end else if (state_q == ST_SCAN) begin
			tok_w[0].valid = (cnt_q < used);
			tok_w[0].cls   = cnt_q[CLS_W-1:0];
		end
	end

	assign use_norm   = (state_q == ST_SCAN);
	assign cell_start = (state_q == ST_ROOT) && rsq_done;
	assign tok_end    = tok_w[FEATURES];
	assign sum_end    = sum_w[FEATURES];

	for (genvar g = 0; g < FEATURES; g++) begin : g_cell
		ncc_cell #(
			.CLASSES(CLASSES),
			.SUM_W  (SUM_W),
			.ROOT_W (ROOT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tab_we   (accept && mode == MODE_LOAD_ROW && slot_ok),
			.tab_idx  (class_slot),
			.tab_data (feat[g]),
			.x_we     (accept && mode == MODE_CLASSIFY),
			.x_data   (feat[g]),
			.use_norm (use_norm),
			.div_start(cell_start),
			.root     (r_root),
			.div_done (cell_done[g]),
			.tok_in   (tok_w[g]),
			.sum_in   (sum_w[g]),
			.tok_out  (tok_w[g+1]),
			.sum_out  (sum_w[g+1])
		);
	end

	// root of the input energy
	ncc_sqrt #(.IN_W(SQ_IN_W)) u_rsq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == ST_SUMSQ) && tok_end.valid && sum_end != '0),
		.operand(SQ_IN_W'(sum_end) << ROOT_SHIFT),
		.done   (rsq_done),
		.root   (r_root)
	);

	// distance roots of best and second
	assign sq_go = (state_q == ST_SQGO);

	ncc_sqrt #(.IN_W(DQ_IN_W)) u_bsq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_go),
		.operand(DQ_IN_W'(best_d2_q >> 2)),
		.done   (bsq_done),
		.root   (b_root)
	);

	ncc_sqrt #(.IN_W(DQ_IN_W)) u_ssq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_go),
		.operand(DQ_IN_W'(sec_d2_q >> 2)),
		.done   (ssq_done),
		.root   (s_root)
	);

	// confidence ramp between inner and outer radius
	assign outer    = radius_q[best_q[CIDX_W-1:0]];
	assign need_div = (outer != '0) && (d_q > D_W'(inner_q)) && (d_q < D_W'(outer))
		&& (outer > inner_q);

	ncc_div #(
		.DEN_W(FEAT_W),
		.Q_W  (FEAT_W - 1)
	) u_cdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start ((state_q == ST_CALC) && need_div),
		.num_hi(outer - d_q[FEAT_W-1:0]),
		.num_lo('0),
		.den   (outer - inner_q),
		.done  (cdiv_done),
		.quo   (cdiv_quo)
	);

	// result register takes a new result when free or being drained
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sent_q      <= 1'b0;
			cnt_q       <= '0;
			best_ok_q   <= 1'b0;
			sec_ok_q    <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && mode == MODE_CLASSIFY) begin
						sent_q  <= 1'b0;
						zero_q  <= 1'b0;
						state_q <= ST_SUMSQ;
					end
				end
				ST_SUMSQ: begin
					sent_q <= 1'b1;
					if (tok_end.valid) begin
						if (sum_end == '0) begin
							zero_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if (rsq_done) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (&cell_done) begin
						cnt_q     <= '0;
						best_ok_q <= 1'b0;
						sec_ok_q  <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_w[0].valid) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (tok_end.valid) begin
						if (!best_ok_q || sum_end < best_d2_q) begin
							sec_ok_q  <= best_ok_q;
							sec_d2_q  <= best_d2_q;
							sec_q     <= best_q;
							best_ok_q <= 1'b1;
							best_d2_q <= sum_end;
							best_q    <= tok_end.cls;
						end else if (!sec_ok_q || sum_end < sec_d2_q) begin
							sec_ok_q <= 1'b1;
							sec_d2_q <= sum_end;
							sec_q    <= tok_end.cls;
						end
						if (5'(tok_end.cls) == used - 1'b1) begin
							state_q <= ST_SQGO;
						end
					end
				end
				ST_SQGO: begin
					state_q <= ST_SQD;
				end
				ST_SQD: begin
					if (bsq_done && ssq_done) begin
						d_q <= b_root;
						if (!sec_ok_q) begin
							sd_q <= DIST_SAT;
						end else if (s_root > D_W'(DIST_SAT)) begin
							sd_q <= DIST_SAT;
						end else begin
							sd_q <= s_root[FEAT_W-1:0];
						end
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (need_div) begin
						state_q <= ST_CONF;
					end else begin
						conf_q  <= ((outer != '0) && (d_q <= D_W'(inner_q))) ? ONE_Q15 : '0;
						state_q <= ST_DONE;
					end
				end
				ST_CONF: begin
					if (cdiv_done) begin
						conf_q  <= FEAT_W'(cdiv_quo);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						zero_out_q  <= zero_q;
						if (zero_q) begin
							known_q     <= 1'b0;
							best_out_q  <= '0;
							sec_valid_q <= 1'b0;
							sec_out_q   <= '0;
							conf_out_q  <= '0;
							bd_out_q    <= DIST_SAT;
							sd_out_q    <= DIST_SAT;
						end else begin
							known_q     <= (d_q <= D_W'(outer));
							best_out_q  <= best_q;
							sec_valid_q <= sec_ok_q;
							sec_out_q   <= sec_ok_q ? sec_q : '0;
							conf_out_q  <= conf_q;
							bd_out_q    <= (d_q > D_W'(DIST_SAT)) ? DIST_SAT
								: d_q[FEAT_W-1:0];
							sd_out_q    <= sd_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign known              = known_q;
	assign best_class         = best_out_q;
	assign second_valid       = sec_valid_q;
	assign second_class       = sec_out_q;
	assign confidence         = conf_out_q;
	assign best_distance      = bd_out_q;
	assign runner_up_distance = sd_out_q;
	assign zero_input         = zero_out_q;

endmodule

// File: hw/rtl/ncc_div.sv
// ncc_div: restoring divider, one quotient bit per cycle.
// Depends on nothing; used by ncc_cell and the top level.
module ncc_div #(
	parameter int DEN_W = 31,
	parameter int Q_W   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] num_hi,   // must be below den
	input  logic [Q_W-1:0]   num_lo,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo
);
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one shift-compare-subtract step
	assign trial = {rem_q, lo_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(Q_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			lo_q  <= {lo_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = lo_q;

endmodule

// File: hw/rtl/ncc_sqrt.sv
// ncc_sqrt: digit-by-digit integer square root, one result bit per cycle.
// Depends on nothing; used by the top level.
module ncc_sqrt #(
	parameter int IN_W = 62   // even
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   operand,
	output logic              done,
	output logic [IN_W/2-1:0] root
);
	localparam int RES_W = IN_W / 2;
	localparam int CNT_W = $clog2(RES_W + 1);

	logic [IN_W-1:0]  op_q;
	logic [RES_W+1:0] rem_q;
	logic [RES_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [RES_W+3:0] acc;
	logic [RES_W+3:0] trial;
	logic [RES_W+3:0] diff;
	logic             ge;

	// bring down two bits, try root*4+1
	assign acc   = {rem_q, op_q[IN_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = acc - trial;
	assign ge    = acc >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(RES_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			op_q   <= op_q << 2;
			rem_q  <= ge ? diff[RES_W+1:0] : acc[RES_W+1:0];
			root_q <= {root_q[RES_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: hw/rtl/ncc_cell.sv
// ncc_cell: one feature lane of the chain. Holds that feature's centroid
// components, the raw and normalised feature, and adds its square term to the
// passing partial sum. Depends on ncc_pkg and ncc_div.
module ncc_cell #(
	parameter int CLASSES = 16,
	parameter int SUM_W   = 36,
	parameter int ROOT_W  = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tab_we,
	input  logic [ncc_pkg::CLS_W-1:0]  tab_idx,
	input  logic [ncc_pkg::FEAT_W-1:0] tab_data,
	input  logic                       x_we,
	input  logic [ncc_pkg::FEAT_W-1:0] x_data,
	input  logic                       use_norm,
	input  logic                       div_start,
	input  logic [ROOT_W-1:0]          root,
	output logic                       div_done,
	input  ncc_pkg::tok_t              tok_in,
	input  logic [SUM_W-1:0]           sum_in,
	output ncc_pkg::tok_t              tok_out,
	output logic [SUM_W-1:0]           sum_out
);
	import ncc_pkg::*;

	localparam int CIDX_W = $clog2(CLASSES);
	localparam int NUM_W  = ROOT_W + 16;

	logic [FEAT_W-1:0]   tab_q [CLASSES];
	logic [FEAT_W-1:0]   x_q;
	logic [FEAT_W-1:0]   n_q;
	tok_t                tok_q;
	logic [SUM_W-1:0]    sum_q;
	logic [FEAT_W-1:0]   cval;
	logic [FEAT_W-1:0]   opnd;
	logic [2*FEAT_W-1:0] sq;
	logic [NUM_W-1:0]    num;
	logic [FEAT_W-1:0]   quo;
	logic                dv_done;

	// centroid components of this feature, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASSES; i++) begin
				tab_q[i] <= '0;
			end
		end else if (tab_we) begin
			tab_q[tab_idx[CIDX_W-1:0]] <= tab_data;
		end
	end

	// square term: raw feature, or distance to the centroid component
	always_comb begin
		cval = tab_q[tok_in.cls[CIDX_W-1:0]];
		if (use_norm) begin
			opnd = (n_q >= cval) ? (n_q - cval) : (cval - n_q);
		end else begin
			opnd = x_q;
		end
		sq = opnd * opnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= sum_in + SUM_W'(sq);
	end

	// normalisation: (x << 28 + root/2) / root
	assign num = (NUM_W'(x_q) << NORM_SHIFT) + NUM_W'(root >> 1);

	ncc_div #(
		.DEN_W(ROOT_W),
		.Q_W  (FEAT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num_hi(num[NUM_W-1:16]),
		.num_lo(num[15:0]),
		.den   (root),
		.done  (dv_done),
		.quo   (quo)
	);

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_q <= x_data;
		end
		if (dv_done) begin
			n_q <= (quo > ONE_Q15) ? ONE_Q15 : quo;
		end
	end

	assign div_done = dv_done;
	assign tok_out  = tok_q;
	assign sum_out  = sum_q;

endmodule

// File: hw/rtl/ncc_checker.sv
// ncc_checker: port-level checks of the classifier, bound to the top level.
// Depends on ncc_pkg and nearest_centroid_classifier_core.
module ncc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic        known,
	input logic [3:0]  best_class,
	input logic        second_valid,
	input logic [3:0]  second_class,
	input logic [15:0] confidence,
	input logic [15:0] best_distance,
	input logic [15:0] runner_up_distance,
	input logic        zero_input
);
	import ncc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_class)
			&& $stable(best_distance) && $stable(confidence))
		else $error("result changed while stalled");

	// a classify request leaves the block busy in the cycle after it is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_CLASSIFY |=> !in_ready)
		else $error("ready straight after classify request");

	// zero input result form
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_input |-> !known && !second_valid && confidence == '0
			&& best_distance == DIST_SAT && runner_up_distance == DIST_SAT)
		else $error("bad zero input result");

	// no second class: index 0 and saturated distance
	a_nosec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !second_valid |-> second_class == '0
			&& runner_up_distance == DIST_SAT)
		else $error("bad empty second class");

	// confidence never above one
	a_conf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> confidence <= ONE_Q15)
		else $error("confidence above one");

endmodule

bind nearest_centroid_classifier_core ncc_checker u_ncc_checker (.*);
